[rtl/core/rbi_pkg.sv]
// shared types, widths and codes for the ray/box intersection core
package rbi_pkg;

  localparam int FRAC_BITS     = 16;
  localparam int TOLERANCE_LSB = 1;

  localparam int W       = 32;                     // field width
  localparam int NAXIS   = 3;
  localparam int NCAND   = 2 * NAXIS;
  localparam int NUM_W   = W + 1;                  // plane - origin
  localparam int DMAG_W  = W;                      // |dir|
  localparam int Q_W     = W - 1;                  // saturated quotient
  localparam int N_W     = NUM_W + FRAC_BITS;      // dividend
  localparam int REM_W   = DMAG_W;                 // partial remainder
  localparam int CMP_W   = DMAG_W + Q_W - FRAC_BITS;
  localparam int PROD_W  = Q_W + DMAG_W;
  localparam int PT_W    = PROD_W - FRAC_BITS + 2; // full-width point
  localparam int CIDX_W  = 3;

  typedef enum logic [CIDX_W-1:0] {
    CFG_BOX_MIN_X = 3'd0,
    CFG_BOX_MIN_Y = 3'd1,
    CFG_BOX_MIN_Z = 3'd2,
    CFG_BOX_MAX_X = 3'd3,
    CFG_BOX_MAX_Y = 3'd4,
    CFG_BOX_MAX_Z = 3'd5
  } cfg_idx_t;

  typedef enum logic [2:0] {
    FACE_NEG_X = 3'd0,
    FACE_POS_X = 3'd1,
    FACE_NEG_Y = 3'd2,
    FACE_POS_Y = 3'd3,
    FACE_NEG_Z = 3'd4,
    FACE_POS_Z = 3'd5
  } face_t;

  localparam face_t FACE_OF [NCAND] = '{FACE_NEG_X, FACE_POS_X, FACE_NEG_Y,
                                        FACE_POS_Y, FACE_NEG_Z, FACE_POS_Z};

  typedef struct packed {
    logic [NAXIS-1:0][W-1:0] bmin;
    logic [NAXIS-1:0][W-1:0] bmax;
  } box_t;

  typedef struct packed {
    logic [NAXIS-1:0][W-1:0] org;
    logic [NAXIS-1:0][W-1:0] dir;
  } ray_t;

  typedef struct packed {
    logic              ok;
    logic              sat;
    logic [REM_W-1:0]  rem;
    logic [Q_W-1:0]    nlo;
    logic [DMAG_W-1:0] dmag;
    logic [Q_W-1:0]    q;
  } div_lane_t;

  typedef struct packed {
    logic              ok;
    logic [Q_W-1:0]    q;
    face_t             face;
    logic [NAXIS-1:0][PT_W-1:0] pt;
  } cand_t;

endpackage

[rtl/core/ray_box_intersect_core.sv]
// top level of the ray/axis-aligned box intersection core
//
//  channel   direction  handshake              payload
//  in_       request    in_valid / in_ready    origin xyz, dir xyz
//  out_      result     out_valid / out_ready  hit, point xyz, hit_t, face
//  cfg_      write      cfg_wr_en              cfg_index, cfg_wdata
//
// one request per cycle unless a result waits on out_ready; 1 setup, 31 divider stages
// (one quotient bit each), 2 point stages, 2 select stages.
// synchronous active-low reset clears valid bits and loads the default box.
// the whole pipeline holds while a result waits on out_ready; nothing lost.
module ray_box_intersect_core (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic signed [rbi_pkg::W-1:0] in_origin_x,
  input  logic signed [rbi_pkg::W-1:0] in_origin_y,
  input  logic signed [rbi_pkg::W-1:0] in_origin_z,
  input  logic signed [rbi_pkg::W-1:0] in_dir_x,
  input  logic signed [rbi_pkg::W-1:0] in_dir_y,
  input  logic signed [rbi_pkg::W-1:0] in_dir_z,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_hit,
  output logic signed [rbi_pkg::W-1:0] out_point_x,
  output logic signed [rbi_pkg::W-1:0] out_point_y,
  output logic signed [rbi_pkg::W-1:0] out_point_z,
  output logic [rbi_pkg::Q_W-1:0] out_hit_t,
  output logic [2:0]            out_face,
  input  logic                  cfg_wr_en,
  input  logic [rbi_pkg::CIDX_W-1:0] cfg_index,
  input  logic [rbi_pkg::W-1:0] cfg_wdata
);
  import rbi_pkg::*;

  box_t box_r;
  logic en;
  ray_t in_ray;

  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  assign in_ray.org = {in_origin_z, in_origin_y, in_origin_x};
  assign in_ray.dir = {in_dir_z, in_dir_y, in_dir_x};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NAXIS; k++) begin
        box_r.bmin[k] <= W'(-32'sd32768);
        box_r.bmax[k] <= W'(32'sd32768);
      end
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_BOX_MIN_X: box_r.bmin[0] <= cfg_wdata;
        CFG_BOX_MIN_Y: box_r.bmin[1] <= cfg_wdata;
        CFG_BOX_MIN_Z: box_r.bmin[2] <= cfg_wdata;
        CFG_BOX_MAX_X: box_r.bmax[0] <= cfg_wdata;
        CFG_BOX_MAX_Y: box_r.bmax[1] <= cfg_wdata;
        CFG_BOX_MAX_Z: box_r.bmax[2] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  logic      prep_vld;
  ray_t      prep_ray;
  div_lane_t [NCAND-1:0] prep_lane;

  rbi_prep u_prep (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (in_valid),
    .in_ray   (in_ray),
    .box      (box_r),
    .out_vld  (prep_vld),
    .out_ray  (prep_ray),
    .out_lane (prep_lane)
  );

  logic div_vld;
  ray_t div_ray;
  logic [NCAND-1:0] div_ok;
  logic [NCAND-1:0][Q_W-1:0] div_q;

  rbi_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (prep_vld),
    .in_ray  (prep_ray),
    .in_lane (prep_lane),
    .out_vld (div_vld),
    .out_ray (div_ray),
    .out_ok  (div_ok),
    .out_q   (div_q)
  );

  logic  pt_vld;
  cand_t [NCAND-1:0] pt_cand;

  rbi_point u_point (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (div_vld),
    .in_ray   (div_ray),
    .in_ok    (div_ok),
    .in_q     (div_q),
    .box      (box_r),
    .out_vld  (pt_vld),
    .out_cand (pt_cand)
  );

  rbi_select u_select (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (en),
    .in_vld      (pt_vld),
    .in_cand     (pt_cand),
    .out_valid   (out_valid),
    .out_hit     (out_hit),
    .out_point_x (out_point_x),
    .out_point_y (out_point_y),
    .out_point_z (out_point_z),
    .out_hit_t   (out_hit_t),
    .out_face    (out_face)
  );

`ifndef SYNTHESIS
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_hit |-> out_hit_t == '0 && out_face == 3'd0 &&
    out_point_x == '0 && out_point_y == '0 && out_point_z == '0)
    else $error("miss result carries nonzero payload");
  a_hit_t_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_hit |-> out_hit_t != '0 && out_face <= 3'd5)
    else $error("hit with zero t or bad face");
  a_reset_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("result valid right after reset");
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(div_q) && $stable(div_vld))
    else $error("pipeline moved during stall");
`endif

endmodule

[rtl/core/rbi_prep.sv]
// slab setup: per-plane numerator, magnitudes and saturation check
module rbi_prep (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic                  in_vld,
  input  rbi_pkg::ray_t         in_ray,
  input  rbi_pkg::box_t         box,
  output logic                  out_vld,
  output rbi_pkg::ray_t         out_ray,
  output rbi_pkg::div_lane_t [rbi_pkg::NCAND-1:0] out_lane
);
  import rbi_pkg::*;

  logic      vld_r;
  ray_t      ray_r;
  div_lane_t [NCAND-1:0] lane_r, lane_nxt;

  always_comb begin
    logic signed [NUM_W-1:0] plane, org, num;
    logic        [NUM_W-1:0] nmag;
    logic        [N_W-1:0]   dvd;
    logic        [DMAG_W-1:0] dmag;
    logic signed [W-1:0]     dir;
    for (int c = 0; c < NCAND; c++) begin
      plane = (c % 2 == 1) ? NUM_W'($signed(box.bmax[c/2])) : NUM_W'($signed(box.bmin[c/2]));
      org   = NUM_W'($signed(in_ray.org[c/2]));
      dir   = $signed(in_ray.dir[c/2]);
      num   = plane - org;
      nmag  = num[NUM_W-1] ? NUM_W'(-num) : num;
      dmag  = dir[W-1] ? DMAG_W'(-dir) : DMAG_W'(dir);
      dvd   = {nmag, {FRAC_BITS{1'b0}}};
      lane_nxt[c].ok   = (dir != '0) && (num != '0) && (num[NUM_W-1] == dir[W-1]);
      // quotient overflows the t field exactly when nmag >= dmag << (Q_W - FRAC_BITS)
      lane_nxt[c].sat  = CMP_W'(nmag) >= (CMP_W'(dmag) << (Q_W - FRAC_BITS));
      lane_nxt[c].rem  = REM_W'(dvd[N_W-1:Q_W]);
      lane_nxt[c].nlo  = dvd[Q_W-1:0];
      lane_nxt[c].dmag = dmag;
      lane_nxt[c].q    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ray_r  <= in_ray;
      lane_r <= lane_nxt;
    end
  end

  assign out_vld  = vld_r;
  assign out_ray  = ray_r;
  assign out_lane = lane_r;

endmodule

[rtl/core/rbi_div.sv]
// pipelined restoring divider, one quotient bit per stage, six lanes
module rbi_div (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic                  in_vld,
  input  rbi_pkg::ray_t         in_ray,
  input  rbi_pkg::div_lane_t [rbi_pkg::NCAND-1:0] in_lane,
  output logic                  out_vld,
  output rbi_pkg::ray_t         out_ray,
  output logic [rbi_pkg::NCAND-1:0] out_ok,
  output logic [rbi_pkg::NCAND-1:0][rbi_pkg::Q_W-1:0] out_q
);
  import rbi_pkg::*;

  logic      vld_r  [1:Q_W];
  ray_t      ray_r  [1:Q_W];
  div_lane_t [NCAND-1:0] lane_r [1:Q_W];

  for (genvar s = 0; s < Q_W; s++) begin : g_stage
    logic      src_vld;
    ray_t      src_ray;
    div_lane_t [NCAND-1:0] src, nxt;

    if (s == 0) begin : g_first
      assign src_vld = in_vld;
      assign src_ray = in_ray;
      assign src     = in_lane;
    end else begin : g_mid
      assign src_vld = vld_r[s];
      assign src_ray = ray_r[s];
      assign src     = lane_r[s];
    end

    always_comb begin
      logic [REM_W:0] sh;
      nxt = src;
      for (int c = 0; c < NCAND; c++) begin
        sh = {src[c].rem, src[c].nlo[Q_W-1-s]};
        if (sh >= {1'b0, src[c].dmag}) begin
          nxt[c].rem          = REM_W'(sh - {1'b0, src[c].dmag});
          nxt[c].q[Q_W-1-s]   = 1'b1;
        end else begin
          nxt[c].rem          = sh[REM_W-1:0];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s+1] <= 1'b0;
      end else if (en) begin
        vld_r[s+1] <= src_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        ray_r[s+1]  <= src_ray;
        lane_r[s+1] <= nxt;
      end
    end
  end

  always_comb begin
    for (int c = 0; c < NCAND; c++) begin
      out_q[c]  = lane_r[Q_W][c].sat ? {Q_W{1'b1}} : lane_r[Q_W][c].q;
      // t must be at least one lsb
      out_ok[c] = lane_r[Q_W][c].ok && (out_q[c] != '0);
    end
  end

  assign out_vld = vld_r[Q_W];
  assign out_ray = ray_r[Q_W];

endmodule

[rtl/core/rbi_point.sv]
// hit point: products in one stage, offset add and box test in the next
module rbi_point (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic                  in_vld,
  input  rbi_pkg::ray_t         in_ray,
  input  logic [rbi_pkg::NCAND-1:0] in_ok,
  input  logic [rbi_pkg::NCAND-1:0][rbi_pkg::Q_W-1:0] in_q,
  input  rbi_pkg::box_t         box,
  output logic                  out_vld,
  output rbi_pkg::cand_t [rbi_pkg::NCAND-1:0] out_cand
);
  import rbi_pkg::*;

  logic  vld1_r, vld2_r;
  ray_t  ray1_r;
  logic  [NCAND-1:0] ok1_r;
  logic  [NCAND-1:0][Q_W-1:0] q1_r;
  logic  [NCAND-1:0][NAXIS-1:0][PROD_W-1:0] prod_r, prod_nxt;
  cand_t [NCAND-1:0] cand_r, cand_nxt;

  always_comb begin
    logic [DMAG_W-1:0] dmag;
    logic signed [W-1:0] dir;
    for (int c = 0; c < NCAND; c++) begin
      for (int k = 0; k < NAXIS; k++) begin
        dir  = $signed(in_ray.dir[k]);
        dmag = dir[W-1] ? DMAG_W'(-dir) : DMAG_W'(dir);
        // own axis takes the plane value directly
        if (k == c / 2) begin
          prod_nxt[c][k] = '0;
        end else begin
          prod_nxt[c][k] = PROD_W'(in_q[c]) * PROD_W'(dmag);
        end
      end
    end
  end

  always_comb begin
    logic signed [PT_W-1:0] lo, hi, bmn, bmx, pt, d;
    logic in_box;
    for (int c = 0; c < NCAND; c++) begin
      in_box = 1'b1;
      for (int k = 0; k < NAXIS; k++) begin
        bmn = PT_W'($signed(box.bmin[k]));
        bmx = PT_W'($signed(box.bmax[k]));
        lo  = ((bmn < bmx) ? bmn : bmx) - PT_W'(TOLERANCE_LSB);
        hi  = ((bmn < bmx) ? bmx : bmn) + PT_W'(TOLERANCE_LSB);
        if (k == c / 2) begin
          pt = (c % 2 == 1) ? bmx : bmn;
        end else begin
          d  = PT_W'(prod_r[c][k] >> FRAC_BITS);
          pt = PT_W'($signed(ray1_r.org[k])) + (ray1_r.dir[k][W-1] ? -d : d);
        end
        if (pt < lo || pt > hi) in_box = 1'b0;
        cand_nxt[c].pt[k] = pt;
      end
      cand_nxt[c].ok   = ok1_r[c] && in_box;
      cand_nxt[c].q    = q1_r[c];
      cand_nxt[c].face = FACE_OF[c];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
    end else if (en) begin
      vld1_r <= in_vld;
      vld2_r <= vld1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ray1_r <= in_ray;
      ok1_r  <= in_ok;
      q1_r   <= in_q;
      prod_r <= prod_nxt;
      cand_r <= cand_nxt;
    end
  end

  assign out_vld  = vld2_r;
  assign out_cand = cand_r;

endmodule

[rtl/core/rbi_select.sv]
// nearest-hit selection: per axis, then across axes into the output register
module rbi_select (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic                  in_vld,
  input  rbi_pkg::cand_t [rbi_pkg::NCAND-1:0] in_cand,
  output logic                  out_valid,
  output logic                  out_hit,
  output logic signed [rbi_pkg::W-1:0] out_point_x,
  output logic signed [rbi_pkg::W-1:0] out_point_y,
  output logic signed [rbi_pkg::W-1:0] out_point_z,
  output logic [rbi_pkg::Q_W-1:0] out_hit_t,
  output logic [2:0]            out_face
);
  import rbi_pkg::*;

  function automatic logic [W-1:0] sat_pt(input logic signed [PT_W-1:0] v);
    logic signed [PT_W-1:0] vmax, vmin;
    vmax = PT_W'($signed({1'b0, {(W-1){1'b1}}}));
    vmin = PT_W'($signed({1'b1, {(W-1){1'b0}}}));
    if (v > vmax) return vmax[W-1:0];
    if (v < vmin) return vmin[W-1:0];
    return v[W-1:0];
  endfunction

  logic  vld1_r, vld_r;
  cand_t [NAXIS-1:0] axis_r, axis_nxt;
  logic  hit_r;
  logic  [NAXIS-1:0][W-1:0] pt_r;
  logic  [Q_W-1:0] t_r;
  face_t face_r;

  // later valid candidate wins only when the earlier is invalid or it is strictly nearer
  always_comb begin
    for (int a = 0; a < NAXIS; a++) begin
      if (in_cand[2*a+1].ok && (!in_cand[2*a].ok || in_cand[2*a+1].q < in_cand[2*a].q)) begin
        axis_nxt[a] = in_cand[2*a+1];
      end else begin
        axis_nxt[a] = in_cand[2*a];
      end
    end
  end

  cand_t best;
  always_comb begin
    best = axis_r[0];
    for (int a = 1; a < NAXIS; a++) begin
      if (axis_r[a].ok && (!best.ok || axis_r[a].q < best.q)) best = axis_r[a];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld_r  <= 1'b0;
    end else if (en) begin
      vld1_r <= in_vld;
      vld_r  <= vld1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      axis_r <= axis_nxt;
      hit_r  <= best.ok;
      t_r    <= best.ok ? best.q : '0;
      face_r <= best.ok ? best.face : FACE_NEG_X;
      for (int k = 0; k < NAXIS; k++) begin
        pt_r[k] <= best.ok ? sat_pt(best.pt[k]) : '0;
      end
    end
  end

  assign out_valid   = vld_r;
  assign out_hit     = hit_r;
  assign out_point_x = $signed(pt_r[0]);
  assign out_point_y = $signed(pt_r[1]);
  assign out_point_z = $signed(pt_r[2]);
  assign out_hit_t   = t_r;
  assign out_face    = face_r;

endmodule

[tb/testbench.sv]
// self-checking testbench for the ray/box intersection core
`timescale 1ns / 100ps

module testbench;
  import rbi_pkg::*;

  typedef struct {
    logic signed [31:0] org [3];
    logic signed [31:0] dir [3];
  } ray_req_t;

  typedef struct {
    logic               hit;
    logic signed [31:0] pt [3];
    logic [30:0]        t;
    logic [2:0]         face;
  } isect_t;

  // expected intersections, worked out from a local copy of the box
  class isect_board;
    logic signed [31:0] bmin [3];
    logic signed [31:0] bmax [3];
    isect_t             pending [$];
    int                 errors;

    function new();
      errors = 0;
      bmin = '{-32768, -32768, -32768};
      bmax = '{32768, 32768, 32768};
    endfunction

    function void set_reg(cfg_idx_t idx, logic [31:0] v);
      case (idx)
        CFG_BOX_MIN_X: bmin[0] = v;
        CFG_BOX_MIN_Y: bmin[1] = v;
        CFG_BOX_MIN_Z: bmin[2] = v;
        CFG_BOX_MAX_X: bmax[0] = v;
        CFG_BOX_MAX_Y: bmax[1] = v;
        CFG_BOX_MAX_Z: bmax[2] = v;
        default: ;
      endcase
    endfunction

    function void note_ray(ray_req_t r);
      longint lo [3], hi [3], p [3], bp [3];
      longint plane, num, o, d;
      longint unsigned q, bt, prod, dm;
      bit found, ok;
      int bf;
      isect_t e;
      found = 0; bt = 0; bf = 0; bp = '{0, 0, 0};
      for (int i = 0; i < 3; i++) begin
        lo[i] = ((bmin[i] < bmax[i]) ? longint'(bmin[i]) : longint'(bmax[i])) - TOLERANCE_LSB;
        hi[i] = ((bmin[i] < bmax[i]) ? longint'(bmax[i]) : longint'(bmin[i])) + TOLERANCE_LSB;
      end
      for (int i = 0; i < 3; i++) begin
        d = r.dir[i];
        if (d == 0) continue;
        for (int j = 0; j < 2; j++) begin
          plane = j ? longint'(bmax[i]) : longint'(bmin[i]);
          num = plane - longint'(r.org[i]);
          if (num == 0 || ((num < 0) != (d < 0))) continue;
          q = ((num < 0 ? -num : num) << FRAC_BITS) / (d < 0 ? -d : d);
          if (q == 0) continue;
          if (q > 64'h7fffffff) q = 64'h7fffffff;
          ok = 1;
          for (int k = 0; k < 3; k++) begin
            o = r.org[k];
            if (k == i) p[k] = plane;
            else if (r.dir[k] == 0) p[k] = o;
            else begin
              dm = (r.dir[k] < 0) ? -longint'(r.dir[k]) : longint'(r.dir[k]);
              prod = (q * dm) >> FRAC_BITS;
              p[k] = (r.dir[k] < 0) ? o - longint'(prod) : o + longint'(prod);
            end
            if (p[k] < lo[k] || p[k] > hi[k]) ok = 0;
          end
          if (ok && (!found || q < bt)) begin
            found = 1; bt = q; bf = 2 * i + j; bp = p;
          end
        end
      end
      e.hit = found;
      for (int k = 0; k < 3; k++) begin
        if (!found) e.pt[k] = 0;
        else if (bp[k] > 64'sd2147483647) e.pt[k] = 32'h7fffffff;
        else if (bp[k] < -64'sd2147483648) e.pt[k] = 32'h80000000;
        else e.pt[k] = bp[k][31:0];
      end
      e.t = found ? bt[30:0] : '0;
      e.face = found ? bf[2:0] : '0;
      pending.push_back(e);
    endfunction

    function void check_result(isect_t a);
      isect_t e;
      if (pending.size() == 0) begin
        $error("result with no request outstanding");
        errors++;
        return;
      end
      e = pending.pop_front();
      if (a.hit !== e.hit) begin
        $error("hit: expected %0d actual %0d", e.hit, a.hit); errors++;
      end
      if (a.pt[0] !== e.pt[0]) begin
        $error("point_x: expected %0d actual %0d", e.pt[0], a.pt[0]); errors++;
      end
      if (a.pt[1] !== e.pt[1]) begin
        $error("point_y: expected %0d actual %0d", e.pt[1], a.pt[1]); errors++;
      end
      if (a.pt[2] !== e.pt[2]) begin
        $error("point_z: expected %0d actual %0d", e.pt[2], a.pt[2]); errors++;
      end
      if (a.t !== e.t) begin
        $error("hit_t: expected %0d actual %0d", e.t, a.t); errors++;
      end
      if (a.face !== e.face) begin
        $error("face: expected %0d actual %0d", e.face, a.face); errors++;
      end
    endfunction
  endclass

  localparam int LATENCY = 36;
  localparam int STALL_LIMIT = 20000;

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_ready;
  logic signed [31:0] in_origin_x = 0, in_origin_y = 0, in_origin_z = 0;
  logic signed [31:0] in_dir_x = 0, in_dir_y = 0, in_dir_z = 0;
  logic out_valid;
  logic out_ready = 0;
  logic out_hit;
  logic signed [31:0] out_point_x, out_point_y, out_point_z;
  logic [30:0] out_hit_t;
  logic [2:0] out_face;
  logic cfg_wr_en = 0;
  logic [2:0] cfg_index = 0;
  logic [31:0] cfg_wdata = 0;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_off = 0;
  int idle_cycles = 0;
  bit timed_out = 0;
  isect_board board = new();

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  ray_box_intersect_core u_top (.*);

  // receiver: ready at random, sampled results checked at the rising edge
  always @(posedge clk) begin
    isect_t a;
    if (rst_n && out_valid && out_ready) begin
      a.hit = out_hit;
      a.pt[0] = out_point_x; a.pt[1] = out_point_y; a.pt[2] = out_point_z;
      a.t = out_hit_t;
      a.face = out_face;
      board.check_result(a);
    end
  end

  always @(negedge clk) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_ready <= 0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // watchdog on cycles with no handshake, no config write and no reset
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n || cfg_wr_en)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic write_reg(cfg_idx_t idx, logic [31:0] v);
    @(negedge clk);
    cfg_wr_en <= 1; cfg_index <= idx; cfg_wdata <= v;
    board.set_reg(idx, v);
    @(negedge clk);
    cfg_wr_en <= 0;
  endtask

  task automatic write_box(logic [31:0] b [6]);
    for (int i = 0; i < 6; i++) write_reg(cfg_idx_t'(i), b[i]);
  endtask

  // valid stays high between back-to-back requests; it drops only on idle
  task automatic send_ray(ray_req_t r);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(negedge clk);
    end
    in_valid <= 1;
    in_origin_x <= r.org[0]; in_origin_y <= r.org[1]; in_origin_z <= r.org[2];
    in_dir_x <= r.dir[0]; in_dir_y <= r.dir[1]; in_dir_z <= r.dir[2];
    do @(posedge clk); while (!in_ready);
    board.note_ray(r);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (board.pending.size() != 0) @(negedge clk);
    repeat (LATENCY + 4) @(negedge clk);
  endtask

  function automatic logic [31:0] rand_coord(int mode);
    case (mode)
      0: return $urandom();
      1: return $signed($urandom_range(262144)) - 131072;
      2: return $signed($urandom_range(4096)) - 2048;
      default: return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
    endcase
  endfunction

  // aim from a random origin toward a random point near the box
  function automatic ray_req_t aimed_ray();
    ray_req_t r;
    logic signed [31:0] tgt;
    for (int k = 0; k < 3; k++) begin
      tgt = ((board.bmin[k] >>> 1) + (board.bmax[k] >>> 1))
            + $signed($urandom_range(80000)) - 40000;
      r.org[k] = rand_coord($urandom_range(3) == 0 ? 0 : 1);
      r.dir[k] = $urandom_range(7) == 0 ? 0 : (tgt - r.org[k]) >>> $urandom_range(4);
    end
    return r;
  endfunction

  function automatic ray_req_t random_ray();
    ray_req_t r;
    for (int k = 0; k < 3; k++) begin
      r.org[k] = rand_coord($urandom_range(3));
      r.dir[k] = $urandom_range(5) == 0 ? 0 : rand_coord($urandom_range(3));
    end
    return r;
  endfunction

  task automatic run_batch(int n);
    for (int i = 0; i < n; i++) send_ray(($urandom_range(9) < 7) ? aimed_ray() : random_ray());
  endtask

  initial begin
    ray_req_t r;
    logic [31:0] box [6];
    repeat (10) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);

    // directed: reset box, axis rays, zero direction, behind origin, extremes
    r.org = '{-131072, 0, 0};       r.dir = '{65536, 0, 0};      send_ray(r);
    r.org = '{131072, 0, 0};        r.dir = '{-65536, 0, 0};     send_ray(r);
    r.org = '{0, -131072, 0};       r.dir = '{0, 65536, 0};      send_ray(r);
    r.org = '{0, 131072, 0};        r.dir = '{0, -65536, 0};     send_ray(r);
    r.org = '{0, 0, -131072};       r.dir = '{0, 0, 65536};      send_ray(r);
    r.org = '{0, 0, 131072};        r.dir = '{0, 0, -65536};     send_ray(r);
    r.org = '{0, 0, 0};             r.dir = '{0, 0, 0};          send_ray(r);
    r.org = '{131072, 0, 0};        r.dir = '{65536, 0, 0};      send_ray(r);
    r.org = '{0, 0, 0};             r.dir = '{65536, 65536, 65536}; send_ray(r);
    r.org = '{-131072, -131072, -131072}; r.dir = '{65536, 65536, 65536}; send_ray(r);
    r.org = '{-32768, 0, 0};        r.dir = '{65536, 0, 0};      send_ray(r);
    r.org = '{-32'sh80000000, 0, 0}; r.dir = '{1, 0, 0};          send_ray(r);
    r.org = '{32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff};
    r.dir = '{-32'sh80000000, -32'sh80000000, -32'sh80000000};   send_ray(r);
    r.org = '{-131072, 32769, 0};   r.dir = '{65536, 0, 0};      send_ray(r);
    r.org = '{-131072, 32770, 0};   r.dir = '{65536, 0, 0};      send_ray(r);
    r.org = '{-32770, 0, 0};        r.dir = '{32'sh7fffffff, 0, 0}; send_ray(r);
    r.org = '{32'hffffffff, 32'hffffffff, 32'hffffffff};
    r.dir = '{32'hffffffff, 32'hffffffff, 32'hffffffff};         send_ray(r);
    drain();

    // huge box: saturated t and far points, all bits of registers
    box = '{32'h80000000, 32'h80000000, 32'h80000000,
            32'h7fffffff, 32'h7fffffff, 32'h7fffffff};
    write_box(box);
    r.org = '{0, 0, 0}; r.dir = '{1, 1, 1}; send_ray(r);
    r.org = '{32'sh80000001, 0, 0}; r.dir = '{-1, 0, 1}; send_ray(r);
    r.org = '{0, 0, 0}; r.dir = '{-1, 1, 0}; send_ray(r);
    drain();

    // inverted box
    box = '{65536, 65536, 65536, -65536, -65536, -65536};
    write_box(box);
    r.org = '{-262144, 0, 0}; r.dir = '{65536, 0, 0}; send_ray(r);
    r.org = '{262144, 0, 0};  r.dir = '{-65536, 0, 0}; send_ray(r);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 66; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 66; end
        default: begin send_idle_pct = 17; recv_stall_pct = 17; end
      endcase
      for (int k = 0; k < 3; k++) begin
        box[k] = $signed($urandom_range(200000)) - 150000;
        box[k + 3] = box[k] + $urandom_range(300000);
        if (ph == 5) begin
          box[k] = $urandom(); box[k + 3] = $urandom();
        end
      end
      write_box(box);
      if (ph == 0) hold_off = 300;  // receiver blocks, pipeline fills
      run_batch(250);
      drain();
    end

    if (board.pending.size() == 0 && board.errors == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end
endmodule

[filelist.f]
rtl/core/rbi_pkg.sv
rtl/core/rbi_prep.sv
rtl/core/rbi_div.sv
rtl/core/rbi_point.sv
rtl/core/rbi_select.sv
rtl/core/ray_box_intersect_core.sv
tb/testbench.sv
